[design/aiil_pkg.sv]
// Shared types and constants for the averaged integral intensity lock.
package aiil_pkg;

  // Field and register widths
  localparam int LEVEL_W  = 16;          // signed Q4.11 levels
  localparam int GAIN_W   = 16;          // unsigned Q8.8 gain
  localparam int LEN_W    = 9;           // batch length and counts
  localparam int SUM_W    = 25;          // running sample sum
  localparam int MAG_W    = SUM_W - 1;   // magnitude of the sum
  localparam int ERR_W    = LEVEL_W + 1; // target minus average
  localparam int PROD_W   = ERR_W + GAIN_W;
  localparam int STEP_W   = PROD_W - 8;  // product back to Q4.11
  localparam int DRV_W    = STEP_W + 1;  // drive plus step before clamp
  localparam int ACT_W    = 2;
  localparam int CIDX_W   = 2;

  // Sequencer step counts (one quotient bit or one gain bit per cycle)
  localparam int DIV_STEPS = MAG_W;
  localparam int MUL_STEPS = GAIN_W;
  localparam int CNT_W     = 5;

  localparam int MAX_BATCH = 256;

  // Reset values of the registers
  localparam logic [GAIN_W-1:0]         GAIN_RST      = 16'd256;
  localparam logic [LEN_W-1:0]          LEN_RST       = 9'd1;
  localparam logic signed [LEVEL_W-1:0] THRESHOLD_RST = -16'sd20275;

  // Input action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_START  = 2'd1,
    ACT_PRESET = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // Register indexes
  localparam logic [CIDX_W-1:0] CFG_LOOP_GAIN    = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_BATCH_LENGTH = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_THRESHOLD    = 2'd2;

  // Sequencer states
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ABS  = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_ERR  = 6'b001000,
    ST_MUL  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

endpackage

[design/averaged_integral_intensity_lock.sv]
// Top level of the averaged integral intensity lock with a bit-serial datapath.
// Start, preset and non-final sample items are accepted one per cycle while not stalled.
// A batch-ending sample takes 24 divide steps, 16 shift-add multiply steps and the sign,
// error and clamp states; with no valid sample it takes only the clamp state. The input
// stalls until the result is in the output register.
// rst_n is synchronous, active low; it restores register defaults and clears state.
module averaged_integral_intensity_lock (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_we,
  input  logic [aiil_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [aiil_pkg::GAIN_W-1:0]          cfg_data,
  // input items
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [aiil_pkg::ACT_W-1:0]           in_action,
  input  logic signed [aiil_pkg::LEVEL_W-1:0]  in_value,
  // result items
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [aiil_pkg::LEVEL_W-1:0]  out_drive_level,
  output logic signed [aiil_pkg::LEVEL_W-1:0]  out_average_level,
  output logic                                 out_applied,
  output logic                                 out_saturated
);
  import aiil_pkg::*;

  // Configuration registers
  logic [GAIN_W-1:0]         gain_r;
  logic [LEN_W-1:0]          len_r;
  logic signed [LEVEL_W-1:0] thr_r;

  // Batch and loop state
  logic signed [SUM_W-1:0]   sum_r;
  logic [LEN_W-1:0]          vcnt_r;
  logic [LEN_W-1:0]          seen_r;
  logic signed [LEVEL_W-1:0] target_r;
  logic signed [LEVEL_W-1:0] drive_r;

  // Sequencer and serial datapath
  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          cnt_r;
  logic signed [SUM_W-1:0]   wsum_r;
  logic                      neg_r;
  logic [MAG_W-1:0]          dvd_r;
  logic [LEN_W-1:0]          rem_r;
  logic [LEN_W-1:0]          div_r;
  logic                      applied_r;
  logic signed [LEVEL_W-1:0] avg_r;
  logic signed [PROD_W-1:0]  erx_r;
  logic signed [PROD_W-1:0]  acc_r;
  logic [GAIN_W-1:0]         gsh_r;

  // Output register
  logic                      out_valid_r;
  logic signed [LEVEL_W-1:0] out_drive_r;
  logic signed [LEVEL_W-1:0] out_avg_r;
  logic                      out_applied_r;
  logic                      out_sat_r;

  logic                      in_acc;
  logic                      is_sample;
  logic                      keep;
  logic signed [SUM_W-1:0]   sum_add;
  logic [LEN_W-1:0]          vcnt_add;
  logic [LEN_W-1:0]          seen_add;
  logic [LEN_W-1:0]          eff_len;
  logic                      batch_end;
  logic [LEN_W:0]            trial;
  logic                      qbit;
  logic [MAG_W-1:0]          mag;
  logic signed [LEVEL_W-1:0] avg_nxt;
  logic signed [ERR_W-1:0]   err_nxt;
  logic signed [STEP_W-1:0]  step;
  logic signed [DRV_W-1:0]   nd;
  logic signed [LEVEL_W-1:0] nd_clip;
  logic                      nd_sat;
  logic                      slot_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  // Batch bookkeeping for a sample item
  assign is_sample = (action_t'(in_action) == ACT_SAMPLE);
  assign keep      = (in_value > thr_r);
  assign sum_add   = sum_r + (keep ? SUM_W'(in_value) : '0);
  assign vcnt_add  = vcnt_r + LEN_W'(keep);
  assign seen_add  = seen_r + LEN_W'(1);

  // Effective batch length: zero acts as one, clipped at the maximum
  always_comb begin
    if (len_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (len_r > LEN_W'(MAX_BATCH)) begin
      eff_len = LEN_W'(MAX_BATCH);
    end else begin
      eff_len = len_r;
    end
  end
  assign batch_end = (seen_add >= eff_len);

  // Magnitude of the batch sum
  assign mag = neg_r ? MAG_W'(-wsum_r) : MAG_W'(wsum_r);

  // One restoring divide step
  assign trial = {rem_r, dvd_r[MAG_W-1]};
  assign qbit  = (trial >= {1'b0, div_r});

  // Signed average and loop error
  assign avg_nxt = neg_r ? -LEVEL_W'(dvd_r) : LEVEL_W'(dvd_r);
  assign err_nxt = ERR_W'(target_r) - ERR_W'(avg_nxt);

  // Step back to Q4.11 (floor), new drive with clamp
  assign step = acc_r[PROD_W-1:8];
  assign nd   = DRV_W'(drive_r) + DRV_W'(step);
  always_comb begin
    if (nd > DRV_W'(32767)) begin
      nd_clip = 16'sh7fff;
      nd_sat  = 1'b1;
    end else if (nd < -DRV_W'(32768)) begin
      nd_clip = -16'sh8000;
      nd_sat  = 1'b1;
    end else begin
      nd_clip = LEVEL_W'(nd);
      nd_sat  = 1'b0;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && is_sample && batch_end) begin
          state_nxt = (vcnt_add == '0) ? ST_FIN : ST_ABS;
        end
      end
      ST_ABS: state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = ST_ERR;
        end
      end
      ST_ERR: state_nxt = ST_MUL;
      ST_MUL: begin
        if (cnt_r == '0) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state, configuration and batch registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gain_r      <= GAIN_RST;
      len_r       <= LEN_RST;
      thr_r       <= THRESHOLD_RST;
      sum_r       <= '0;
      vcnt_r      <= '0;
      seen_r      <= '0;
      target_r    <= '0;
      drive_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // register writes
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LOOP_GAIN: begin
            if (cfg_data != '0) begin
              gain_r <= cfg_data;
            end
          end
          CFG_BATCH_LENGTH: len_r <= cfg_data[LEN_W-1:0];
          CFG_THRESHOLD:    thr_r <= cfg_data;
          default: ;
        endcase
      end

      // input items
      if (in_acc) begin
        unique case (action_t'(in_action))
          ACT_START: begin
            target_r <= in_value;
            sum_r    <= '0;
            vcnt_r   <= '0;
            seen_r   <= '0;
          end
          ACT_PRESET: drive_r <= in_value;
          ACT_SAMPLE: begin
            if (batch_end) begin
              sum_r  <= '0;
              vcnt_r <= '0;
              seen_r <= '0;
            end else begin
              sum_r  <= sum_add;
              vcnt_r <= vcnt_add;
              seen_r <= seen_add;
            end
          end
          default: ;
        endcase
      end

      // drive update and result hand-off
      if (state_r == ST_FIN && slot_free) begin
        out_valid_r <= 1'b1;
        if (applied_r) begin
          drive_r <= nd_clip;
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Serial datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        wsum_r    <= sum_add;
        neg_r     <= sum_add[SUM_W-1];
        div_r     <= vcnt_add;
        applied_r <= (vcnt_add != '0);
      end
      ST_ABS: begin
        dvd_r <= mag;
        rem_r <= '0;
        cnt_r <= CNT_W'(DIV_STEPS - 1);
      end
      ST_DIV: begin
        rem_r <= qbit ? LEN_W'(trial - {1'b0, div_r}) : LEN_W'(trial);
        dvd_r <= {dvd_r[MAG_W-2:0], qbit};
        cnt_r <= cnt_r - CNT_W'(1);
      end
      ST_ERR: begin
        avg_r <= avg_nxt;
        erx_r <= PROD_W'(err_nxt);
        acc_r <= '0;
        gsh_r <= gain_r;
        cnt_r <= CNT_W'(MUL_STEPS - 1);
      end
      ST_MUL: begin
        if (gsh_r[0]) begin
          acc_r <= acc_r + erx_r;
        end
        erx_r <= erx_r <<< 1;
        gsh_r <= gsh_r >> 1;
        cnt_r <= cnt_r - CNT_W'(1);
      end
      ST_FIN: begin
        if (slot_free) begin
          out_applied_r <= applied_r;
          if (applied_r) begin
            out_drive_r <= nd_clip;
            out_avg_r   <= avg_r;
            out_sat_r   <= nd_sat;
          end else begin
            out_drive_r <= drive_r;
            out_avg_r   <= '0;
            out_sat_r   <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_drive_level   = out_drive_r;
  assign out_average_level = out_avg_r;
  assign out_applied       = out_applied_r;
  assign out_saturated     = out_sat_r;

endmodule

[design/aiil_checker.sv]
// Port-level checks for the averaged integral intensity lock, with bind.
module aiil_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [aiil_pkg::LEVEL_W-1:0] out_drive_level,
  input logic signed [aiil_pkg::LEVEL_W-1:0] out_average_level,
  input logic                                out_applied,
  input logic                                out_saturated
);
  import aiil_pkg::*;

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_drive_level)
      && $stable(out_average_level) && $stable(out_applied) && $stable(out_saturated))
    else $error("result item changed while stalled");

  // no result right after reset
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a batch with no valid sample reports zero average and no clipping
  a_not_applied: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_applied |-> out_average_level == '0 && !out_saturated)
    else $error("unapplied result carries average or saturation");

  // a new result never appears in the cycle after an accepted item
  a_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_valid && !in_stall))
    else $error("result appeared directly after an accepted item");

endmodule

bind averaged_integral_intensity_lock aiil_checker u_aiil_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_drive_level   (out_drive_level),
  .out_average_level (out_average_level),
  .out_applied       (out_applied),
  .out_saturated     (out_saturated)
);
